// File: rtl/tlb_lookup_fill_counter_lru_macros.svh
// Assertion macros shared by the translation buffer RTL.
`ifndef TLB_LOOKUP_FILL_COUNTER_LRU_MACROS_SVH
`define TLB_LOOKUP_FILL_COUNTER_LRU_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication checked at every rising clock edge outside reset.
`define TLBL_ASSERT_IMP(name, clk, rst, cond, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);
// Next-cycle implication checked at every rising clock edge outside reset.
`define TLBL_ASSERT_NXT(name, clk, rst, cond, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);
`else
`define TLBL_ASSERT_IMP(name, clk, rst, cond, expr, msg)
`define TLBL_ASSERT_NXT(name, clk, rst, cond, expr, msg)
`endif

`endif

// File: rtl/tlbl_pkg.sv
// Shared types, codes and default sizes for the translation buffer.
package tlbl_pkg;

   localparam int TLB_ENTRIES    = 16;
   localparam int TLB_PAGE_BITS  = 20;
   localparam int TLB_FRAME_BITS = 20;

   localparam int CMD_BITS       = 2;
   localparam int OUT_FRAME_BITS = 20;
   localparam int OUT_INDEX_BITS = 4;

   localparam logic [CMD_BITS-1:0] CMD_LOOKUP = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_FILL   = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_FLUSH  = 2'd2;

   typedef struct packed {
      logic load_item;
      logic capture;
      logic commit;
      logic load_result;
   } tlbl_ctl_type;

endpackage

// File: rtl/tlbl_if.sv
// Valid/ready channel interfaces for requests and responses.
interface tlbl_req_if import tlbl_pkg::*; #(
   parameter int PAGE_BITS  = TLB_PAGE_BITS,
   parameter int FRAME_BITS = TLB_FRAME_BITS
);
   logic                  valid;
   logic                  ready;
   logic [CMD_BITS-1:0]   command;
   logic [PAGE_BITS-1:0]  page_number;
   logic [FRAME_BITS-1:0] frame_number;

   modport source (output valid, command, page_number, frame_number, input ready);
   modport sink (input valid, command, page_number, frame_number, output ready);
endinterface

interface tlbl_rsp_if import tlbl_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic                      status;
   logic [OUT_FRAME_BITS-1:0] frame_out;
   logic [OUT_INDEX_BITS-1:0] entry_index;
   logic                      was_replacement;

   modport source (output valid, status, frame_out, entry_index, was_replacement,
                   input ready);
   modport sink (input valid, status, frame_out, entry_index, was_replacement,
                 output ready);
endinterface

// File: rtl/tlb_lookup_fill_counter_lru.sv
// Top level of the fully associative translation buffer with counter LRU.
//
//   channel   direction  item contents
//   req_bus   in         command, page_number, frame_number
//   rsp_bus   out        status, frame_out, entry_index, was_replacement
//
// After acceptance an item passes a match stage that registers the match, free and
// zero-count vectors, an update stage that picks the entry, updates the counters and
// accesses the frame RAM, and a finish stage that loads the output register.
// A new item is accepted in the cycle its predecessor's result is loaded.
// Reset is synchronous and clears the valid bits, the LRU counters and the controller.
// A stalled response holds the block in its final stage until the output register frees.
`include "tlb_lookup_fill_counter_lru_macros.svh"

module tlb_lookup_fill_counter_lru import tlbl_pkg::*; #(
   parameter int ENTRIES    = TLB_ENTRIES,
   parameter int PAGE_BITS  = TLB_PAGE_BITS,
   parameter int FRAME_BITS = TLB_FRAME_BITS
) (
   input logic         clock,
   input logic         reset,
   tlbl_req_if.sink    req_bus,
   tlbl_rsp_if.source  rsp_bus
);

   tlbl_ctl_type ctl;

   tlbl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .ctl       (ctl)
   );

   tlbl_dp #(
      .ENTRIES    (ENTRIES),
      .PAGE_BITS  (PAGE_BITS),
      .FRAME_BITS (FRAME_BITS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .ctl                 (ctl),
      .req_command         (req_bus.command),
      .req_page_number     (req_bus.page_number),
      .req_frame_number    (req_bus.frame_number),
      .rsp_status          (rsp_bus.status),
      .rsp_frame_out       (rsp_bus.frame_out),
      .rsp_entry_index     (rsp_bus.entry_index),
      .rsp_was_replacement (rsp_bus.was_replacement)
   );

   `TLBL_ASSERT_NXT(a_accept_to_match, clock, reset, req_bus.valid && req_bus.ready, ctl.capture, "accepted item did not enter the match stage")
   `TLBL_ASSERT_NXT(a_match_to_commit, clock, reset, ctl.capture, ctl.commit, "match stage was not followed by the update stage")
   `TLBL_ASSERT_IMP(a_miss_fields, clock, reset, rsp_bus.valid && rsp_bus.status, rsp_bus.frame_out == '0 && rsp_bus.entry_index == '0 && !rsp_bus.was_replacement, "miss response carries nonzero fields")
   `TLBL_ASSERT_IMP(a_replace_fields, clock, reset, rsp_bus.valid && rsp_bus.was_replacement, rsp_bus.frame_out == '0 && !rsp_bus.status, "replacement response carries a frame or a miss")

endmodule

// File: rtl/tlbl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tlbl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/tlbl_ctrl.sv
// Sequencing state machine and response handshake for the translation buffer.
module tlbl_ctrl import tlbl_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output tlbl_ctl_type ctl
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_MATCH  = 4'b0010,
      ST_UPDATE = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      accept;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !reset &&
                      ((state_ff == ST_IDLE) || ((state_ff == ST_FINISH) && out_free));
   assign accept    = req_valid && req_ready;

   assign ctl.load_item   = accept;
   assign ctl.capture     = (state_ff == ST_MATCH);
   assign ctl.commit      = (state_ff == ST_UPDATE);
   assign ctl.load_result = (state_ff == ST_FINISH) && out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_MATCH;
            end
         end
         ST_MATCH:  state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_FINISH;
         ST_FINISH: begin
            if (out_free) begin
               state_in = accept ? ST_MATCH : ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.load_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: rtl/tlbl_dp.sv
// Tag store, match logic, LRU counters, frame RAM and result registers.
module tlbl_dp import tlbl_pkg::*; #(
   parameter int ENTRIES    = TLB_ENTRIES,
   parameter int PAGE_BITS  = TLB_PAGE_BITS,
   parameter int FRAME_BITS = TLB_FRAME_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  tlbl_ctl_type              ctl,
   input  logic [CMD_BITS-1:0]       req_command,
   input  logic [PAGE_BITS-1:0]      req_page_number,
   input  logic [FRAME_BITS-1:0]     req_frame_number,
   output logic                      rsp_status,
   output logic [OUT_FRAME_BITS-1:0] rsp_frame_out,
   output logic [OUT_INDEX_BITS-1:0] rsp_entry_index,
   output logic                      rsp_was_replacement
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam logic [IDX_W-1:0] COUNT_TOP = IDX_W'(ENTRIES - 1);

   logic [CMD_BITS-1:0]   cmd_ff;
   logic [PAGE_BITS-1:0]  page_ff;
   logic [FRAME_BITS-1:0] frame_ff;

   logic [ENTRIES-1:0]    valid_ff, valid_in;
   logic [IDX_W-1:0]      count_ff [ENTRIES];
   logic [IDX_W-1:0]      count_in [ENTRIES];
   logic [PAGE_BITS-1:0]  page_store_ff [ENTRIES];
   logic [ENTRIES-1:0]    page_we;

   logic [ENTRIES-1:0]    match_ff, free_ff, zero_ff;
   logic [ENTRIES-1:0]    match_in, free_in, zero_in;

   logic [ENTRIES-1:0]    hit_1h, free_1h, zero_1h;
   logic [IDX_W-1:0]      hit_idx, free_idx, zero_idx, slot_idx, hit_count;
   logic                  any_hit, any_free;

   logic                  res_status_ff, res_status_in;
   logic                  res_use_frame_ff, res_use_frame_in;
   logic                  res_repl_ff, res_repl_in;
   logic [IDX_W-1:0]      res_index_ff, res_index_in;

   logic                  ram_we;
   logic [FRAME_BITS-1:0] ram_rd_data;

   logic                      rsp_status_ff;
   logic [OUT_FRAME_BITS-1:0] rsp_frame_ff;
   logic [OUT_INDEX_BITS-1:0] rsp_index_ff;
   logic                      rsp_repl_ff;

   always_ff @(posedge clock) begin
      if (ctl.load_item) begin
         cmd_ff   <= req_command;
         page_ff  <= req_page_number;
         frame_ff <= req_frame_number;
      end
   end

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match_in[i] = valid_ff[i] && (page_store_ff[i] == page_ff);
         free_in[i]  = !valid_ff[i];
         zero_in[i]  = (count_ff[i] == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         match_ff <= match_in;
         free_ff  <= free_in;
         zero_ff  <= zero_in;
      end
   end

   always_comb begin
      hit_1h    = match_ff & (~match_ff + ENTRIES'(1));
      free_1h   = free_ff & (~free_ff + ENTRIES'(1));
      zero_1h   = zero_ff & (~zero_ff + ENTRIES'(1));
      any_hit   = |match_ff;
      any_free  = |free_ff;
      hit_idx   = '0;
      free_idx  = '0;
      zero_idx  = '0;
      hit_count = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_idx   = hit_idx | (IDX_W'(i) & {IDX_W{hit_1h[i]}});
         free_idx  = free_idx | (IDX_W'(i) & {IDX_W{free_1h[i]}});
         zero_idx  = zero_idx | (IDX_W'(i) & {IDX_W{zero_1h[i]}});
         hit_count = hit_count | (count_ff[i] & {IDX_W{hit_1h[i]}});
      end
      slot_idx = any_free ? free_idx : zero_idx;
   end

   always_comb begin
      valid_in         = valid_ff;
      page_we          = '0;
      ram_we           = 1'b0;
      res_status_in    = 1'b0;
      res_use_frame_in = 1'b0;
      res_repl_in      = 1'b0;
      res_index_in     = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         count_in[i] = count_ff[i];
      end
      if (ctl.commit) begin
         unique case (cmd_ff)
            CMD_LOOKUP: begin
               res_status_in = !any_hit;
               if (any_hit) begin
                  res_use_frame_in = 1'b1;
                  res_index_in     = hit_idx;
                  for (int i = 0; i < ENTRIES; i++) begin
                     if (hit_1h[i]) begin
                        count_in[i] = COUNT_TOP;
                     end else if (count_ff[i] > hit_count) begin
                        count_in[i] = count_ff[i] - IDX_W'(1);
                     end
                  end
               end
            end
            CMD_FILL: begin
               ram_we       = 1'b1;
               res_index_in = slot_idx;
               res_repl_in  = !any_free;
               for (int i = 0; i < ENTRIES; i++) begin
                  if (slot_idx == IDX_W'(i)) begin
                     valid_in[i] = 1'b1;
                     page_we[i]  = 1'b1;
                  end
               end
            end
            CMD_FLUSH: begin
               valid_in = '0;
            end
            default: begin
               valid_in = valid_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         for (int i = 0; i < ENTRIES; i++) begin
            count_ff[i] <= count_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (page_we[i]) begin
            page_store_ff[i] <= page_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         res_status_ff    <= res_status_in;
         res_use_frame_ff <= res_use_frame_in;
         res_repl_ff      <= res_repl_in;
         res_index_ff     <= res_index_in;
      end
   end

   tlbl_ram #(
      .WIDTH (FRAME_BITS),
      .DEPTH (ENTRIES)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (slot_idx),
      .wr_data (frame_ff),
      .rd_en   (ctl.commit),
      .rd_addr (hit_idx),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (ctl.load_result) begin
         rsp_status_ff <= res_status_ff;
         rsp_frame_ff  <= res_use_frame_ff ? OUT_FRAME_BITS'(ram_rd_data) : '0;
         rsp_index_ff  <= OUT_INDEX_BITS'(res_index_ff);
         rsp_repl_ff   <= res_repl_ff;
      end
   end

   assign rsp_status          = rsp_status_ff;
   assign rsp_frame_out       = rsp_frame_ff;
   assign rsp_entry_index     = rsp_index_ff;
   assign rsp_was_replacement = rsp_repl_ff;

endmodule
